// ----- rtl/core/yrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types, coefficient table and channel clamp for the YCbCr to RGB565
// pixel converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int YTERM_W = 18;
  localparam int PROD_W  = 19;
  localparam int SUM_W   = 20;

  typedef enum logic [1:0] {
    REG_WIDE_RANGE = 2'd0,
    REG_BT709      = 2'd1,
    REG_GRAY_MODE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0] gain_y;
    logic [4:0] black;
    logic [9:0] k_rv;
    logic [9:0] k_gu;
    logic [9:0] k_gv;
    logic [9:0] k_bu;
  } coef_t;

  // indexed by {bt709, wide_range}
  localparam coef_t COEF_TABLE [4] = '{
    '{9'd298, 5'd16, 10'd409, 10'd100, 10'd208, 10'd516},
    '{9'd256, 5'd0,  10'd359, 10'd88,  10'd183, 10'd454},
    '{9'd298, 5'd16, 10'd459, 10'd55,  10'd136, 10'd541},
    '{9'd256, 5'd0,  10'd403, 10'd48,  10'd120, 10'd475}
  };

  typedef struct packed {
    logic signed [YTERM_W-1:0] yterm;
    logic signed [8:0]         u;
    logic signed [8:0]         v;
    logic [9:0]                k_rv;
    logic [9:0]                k_gu;
    logic [9:0]                k_gv;
    logic [9:0]                k_bu;
  } work_t;

  // floor(x / 256) clamped to 0..255
  function automatic logic [7:0] chan_clamp(input logic signed [SUM_W-1:0] x);
    logic [7:0] res;
    if (x[SUM_W-1]) begin
      res = 8'd0;
    end else if (x[SUM_W-2:16] != '0) begin
      res = 8'hFF;
    end else begin
      res = x[15:8];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/yrgb_front.sv -----
// ----------------------------------------------------------------------------
// yrgb_front
// Accepts pixels, selects the coefficient set, centers chroma and forms the
// luma term.
// ----------------------------------------------------------------------------
module yrgb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     luma,
  input  logic [7:0]     chroma_blue,
  input  logic [7:0]     chroma_red,
  input  logic           pix_valid,
  output logic           pix_ready,
  input  logic           wide_range,
  input  logic           bt709,
  input  logic           gray_mode,
  output logic           work_valid,
  output yrgb_pkg::work_t work,
  input  logic           work_ready
);
  import yrgb_pkg::*;

  coef_t              coef;
  logic signed [8:0]  ydiff;
  logic signed [PROD_W-1:0] yprod;
  logic signed [PROD_W-1:0] yterm_calc;
  work_t              work_next;

  always_comb begin
    coef       = COEF_TABLE[{bt709, wide_range}];
    ydiff      = $signed({1'b0, luma}) - $signed({4'b0000, coef.black});
    yprod      = $signed({1'b0, coef.gain_y}) * ydiff;
    yterm_calc = yprod + PROD_W'(128);
    work_next.yterm = yterm_calc[YTERM_W-1:0];
    work_next.u     = $signed({1'b0, chroma_blue}) - 9'sd128;
    work_next.v     = $signed({1'b0, chroma_red}) - 9'sd128;
    work_next.k_rv  = gray_mode ? 10'd0 : coef.k_rv;
    work_next.k_gu  = gray_mode ? 10'd0 : coef.k_gu;
    work_next.k_gv  = gray_mode ? 10'd0 : coef.k_gv;
    work_next.k_bu  = gray_mode ? 10'd0 : coef.k_bu;
  end

  assign pix_ready = !work_valid || work_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (pix_ready) begin
      work_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      work <= work_next;
    end
  end

endmodule

// ----- rtl/core/yrgb_queue.sv -----
// ----------------------------------------------------------------------------
// yrgb_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module yrgb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  yrgb_pkg::work_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output yrgb_pkg::work_t rd_item
);
  import yrgb_pkg::*;

  work_t      entry0;
  work_t      entry1;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = rd_ptr ? entry1 : entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wr_ptr) begin
      entry0 <= wr_item;
    end
    if (push && wr_ptr) begin
      entry1 <= wr_item;
    end
  end

endmodule

// ----- rtl/core/yrgb_back.sv -----
// ----------------------------------------------------------------------------
// yrgb_back
// Chroma products, channel sums, clamp and RGB565 packing.
// ----------------------------------------------------------------------------
module yrgb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            work_valid,
  output logic            work_ready,
  input  yrgb_pkg::work_t work,
  output logic            rgb_valid,
  input  logic            rgb_ready,
  output logic [15:0]     rgb565
);
  import yrgb_pkg::*;

  logic                      s1_valid;
  logic signed [YTERM_W-1:0] yterm;
  logic signed [PROD_W-1:0]  prod_rv;
  logic signed [PROD_W-1:0]  prod_gu;
  logic signed [PROD_W-1:0]  prod_gv;
  logic signed [PROD_W-1:0]  prod_bu;
  logic                      out_en;
  logic                      s1_en;
  logic signed [SUM_W-1:0]   yterm_ext;
  logic signed [SUM_W-1:0]   r_sum;
  logic signed [SUM_W-1:0]   g_sum;
  logic signed [SUM_W-1:0]   b_sum;
  logic [7:0]                r;
  logic [7:0]                g;
  logic [7:0]                b;
  logic [15:0]               rgb565_next;

  assign out_en     = !rgb_valid || rgb_ready;
  assign s1_en      = !s1_valid || out_en;
  assign work_ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= work_valid;
      end
      if (out_en) begin
        rgb_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work_valid && s1_en) begin
      yterm   <= work.yterm;
      prod_rv <= $signed({1'b0, work.k_rv}) * work.v;
      prod_gu <= $signed({1'b0, work.k_gu}) * work.u;
      prod_gv <= $signed({1'b0, work.k_gv}) * work.v;
      prod_bu <= $signed({1'b0, work.k_bu}) * work.u;
    end
  end

  always_comb begin
    yterm_ext = {{(SUM_W-YTERM_W){yterm[YTERM_W-1]}}, yterm};
    r_sum = yterm_ext + $signed({prod_rv[PROD_W-1], prod_rv});
    g_sum = yterm_ext - $signed({prod_gu[PROD_W-1], prod_gu})
                      - $signed({prod_gv[PROD_W-1], prod_gv});
    b_sum = yterm_ext + $signed({prod_bu[PROD_W-1], prod_bu});
    r = chan_clamp(r_sum);
    g = chan_clamp(g_sum);
    b = chan_clamp(b_sum);
    rgb565_next = {r[7:3], g[7:2], b[7:3]};
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_en) begin
      rgb565 <= rgb565_next;
    end
  end

endmodule

// ----- rtl/core/yuv_to_rgb565_pixel.sv -----
// ----------------------------------------------------------------------------
// yuv_to_rgb565_pixel
// Path from pixel transaction to rgb_valid: front register, queue, product
// register, output register. Throughput: one pixel per cycle while
// rgb_ready does not stall the output.
// Reset clears the configuration to BT.601 TV range color and empties
// every stage; no clearing pass.
// ----------------------------------------------------------------------------
module yuv_to_rgb565_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_ready,
  input  logic [7:0]  luma,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  chroma_red,
  output logic        rgb_valid,
  input  logic        rgb_ready,
  output logic [15:0] rgb565,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);
  import yrgb_pkg::*;

  logic  wide_range;
  logic  bt709;
  logic  gray_mode;
  logic  fq_valid;
  logic  fq_ready;
  work_t fq_item;
  logic  qb_valid;
  logic  qb_ready;
  work_t qb_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_range <= 1'b0;
      bt709      <= 1'b0;
      gray_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDE_RANGE: wide_range <= cfg_data;
        REG_BT709:      bt709      <= cfg_data;
        REG_GRAY_MODE:  gray_mode  <= cfg_data;
        default: ;
      endcase
    end
  end

  yrgb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .wide_range  (wide_range),
    .bt709       (bt709),
    .gray_mode   (gray_mode),
    .work_valid  (fq_valid),
    .work        (fq_item),
    .work_ready  (fq_ready)
  );

  yrgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  yrgb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (qb_valid),
    .work_ready (qb_ready),
    .work       (qb_item),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .rgb565     (rgb565)
  );

endmodule
